### sv/sssag_pkg.sv
// ============================================================================
// sssag_pkg
// Shared types, register indexes, fault codes and axis normalisation for the
// strided slice scatter address generator.
// ============================================================================
package sssag_pkg;

    localparam int NUM_AXES      = 4;
    localparam int POS_W         = 17;
    localparam int SIZE_W        = 15;
    localparam int STEP_W        = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 64;
    localparam int IN_VALUE_W    = 64;
    localparam int OUT_ADDR_W    = 32;
    localparam int OUT_VALUE_W   = 64;
    localparam int E2_W          = 2 * SIZE_W;
    localparam int E1_W          = 3 * SIZE_W;
    localparam int TOTAL_W       = 4 * SIZE_W;
    localparam int QUEUE_DEPTH   = 4;
    localparam int SETTLE_CYCLES = 4;
    localparam int BUSY_W        = $clog2(SETTLE_CYCLES + 1);

    localparam logic [CFG_DATA_W-1:0] AXIS_SETUP_RESET = 64'd65537;

    localparam logic [CFG_ADDR_W-1:0] REG_AXIS0 = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS1 = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS2 = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_AXIS3 = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_MODE  = 3'd4;

    typedef enum logic [1:0] {
        FAULT_OK          = 2'd0,
        FAULT_DONE        = 2'd1,
        FAULT_ZERO_STRIDE = 2'd2,
        FAULT_RANGE       = 2'd3
    } fault_t;

    typedef logic [POS_W-1:0] pos_t;

    typedef struct packed {
        logic        [SIZE_W-1:0] size;
        logic signed [POS_W-1:0]  beg;
        logic signed [POS_W-1:0]  lim;
        logic signed [STEP_W-1:0] step;
    } axis_norm_t;

    typedef struct packed {
        axis_norm_t [NUM_AXES-1:0] axis;
        logic                      zero_stride;
    } cfg_walk_t;

    // element counts of the inner axes, outermost product last
    typedef struct packed {
        logic [SIZE_W-1:0]  e3;
        logic [E2_W-1:0]    e2;
        logic [E1_W-1:0]    e1;
        logic [TOTAL_W-1:0] total;
    } cfg_scale_t;

    typedef struct packed {
        pos_t [NUM_AXES-1:0] pos;
        fault_t              fault;
        logic                last;
    } q_ctrl_t;

    localparam axis_norm_t FIXED_AXIS = '{
        size: 15'd1,
        beg:  17'sd0,
        lim:  17'sd1,
        step: 16'sd1
    };

    function automatic axis_norm_t normalize(input logic [CFG_DATA_W-1:0] r,
                                             input logic strided);
        logic signed [17:0] s;
        logic signed [17:0] b;
        logic signed [17:0] e;
        axis_norm_t a;
        s = {{2{r[15]}}, r[15:0]};
        b = {{2{r[31]}}, r[31:16]};
        e = {{2{r[47]}}, r[47:32]};
        if (s < 18'sd0)
            s = 18'sd0;
        if (strided)
        begin
            if (e == 18'sd0 && b < 18'sd0)
                e = e + s;
            if (e < 18'sd0)
            begin
                e = e + s;
                if (e < 18'sd0)
                    e = 18'sd0;
            end
            if (e > s)
                e = s;
        end
        if (b < 18'sd0)
        begin
            b = b + s;
            if (b < 18'sd0)
                b = 18'sd0;
        end
        if (b > s)
            b = s;
        if (!strided)
        begin
            if (e < 18'sd0)
            begin
                e = e + s;
                if (e < 18'sd0)
                    e = 18'sd0;
            end
            e = b + e;
        end
        a.size = s[SIZE_W-1:0];
        a.beg  = b[POS_W-1:0];
        a.lim  = e[POS_W-1:0];
        a.step = strided ? $signed(r[63:48]) : 16'sd1;
        return a;
    endfunction

    function automatic logic inside_walk(input logic signed [17:0] n,
                                         input axis_norm_t a);
        logic signed [17:0] lim_ext;
        lim_ext = {a.lim[POS_W-1], a.lim};
        return (a.step > 16'sd0) ? (n < lim_ext) : (n > lim_ext);
    endfunction

endpackage

### sv/sssag_cfg.sv
// ============================================================================
// sssag_cfg
// Configuration registers, per-axis normalisation and inner-size products.
// ============================================================================
module sssag_cfg #(
    parameter int AXES = 4
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_we,
    input  logic [sssag_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  logic [sssag_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    output sssag_pkg::cfg_walk_t               walk,
    output sssag_pkg::cfg_scale_t              scale,
    output logic                               busy
);
    import sssag_pkg::*;

    logic [CFG_DATA_W-1:0] setup_reg [NUM_AXES];
    logic                  mode_reg;
    logic [BUSY_W-1:0]     busy_reg;
    axis_norm_t            norm_reg [NUM_AXES];
    logic                  zero_reg;
    logic [E2_W-1:0]       e2_reg;
    logic [E1_W-1:0]       e1_reg;
    logic [TOTAL_W-1:0]    total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
                setup_reg[k] <= AXIS_SETUP_RESET;
            mode_reg <= 1'b0;
            busy_reg <= BUSY_W'(SETTLE_CYCLES);
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr) inside
                    REG_AXIS0, REG_AXIS1, REG_AXIS2, REG_AXIS3:
                        setup_reg[cfg_addr[1:0]] <= cfg_wdata;
                    REG_MODE:
                        mode_reg <= cfg_wdata[0];
                    default:
                        ;
                endcase
                busy_reg <= BUSY_W'(SETTLE_CYCLES);
            end
            else if (busy_reg != '0)
                busy_reg <= busy_reg - 1'b1;
        end
    end

    // derived values chase the registers, one product per cycle
    always_ff @(posedge clk)
    begin
        logic zero_any;
        zero_any = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            if (k < NUM_AXES - AXES)
                norm_reg[k] <= FIXED_AXIS;
            else
            begin
                norm_reg[k] <= normalize(setup_reg[k], mode_reg);
                if (mode_reg && setup_reg[k][63:48] == '0)
                    zero_any = 1'b1;
            end
        end
        zero_reg  <= zero_any;
        e2_reg    <= norm_reg[3].size * norm_reg[2].size;
        e1_reg    <= e2_reg * norm_reg[1].size;
        total_reg <= e1_reg * norm_reg[0].size;
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
            walk.axis[k] = norm_reg[k];
        walk.zero_stride = zero_reg;
    end

    assign scale.e3    = norm_reg[3].size;
    assign scale.e2    = e2_reg;
    assign scale.e1    = e1_reg;
    assign scale.total = total_reg;
    assign busy        = (busy_reg != '0);

endmodule

### sv/sssag_front.sv
// ============================================================================
// sssag_front
// Input handshake and odometer walk: classifies each beat and queues its
// axis positions for address generation.
// ============================================================================
module sssag_front (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic                  first,
    input  logic                  queue_ready,
    input  logic                  cfg_busy,
    input  sssag_pkg::cfg_walk_t  walk,
    output logic                  push,
    output sssag_pkg::q_ctrl_t    ctrl
);
    import sssag_pkg::*;

    pos_t pos_reg [NUM_AXES];
    logic finished_reg;

    pos_t pos_start [NUM_AXES];
    pos_t pos_adv   [NUM_AXES];
    logic fin_now;
    logic carry;

    assign s_tready = queue_ready && !cfg_busy;
    assign push     = s_tvalid && s_tready;

    always_comb
    begin
        logic begin_out;
        logic signed [17:0] n;
        begin_out = 1'b0;
        for (int k = 0; k < NUM_AXES; k++)
        begin
            pos_start[k] = first ? walk.axis[k].beg : pos_reg[k];
            if (!inside_walk({walk.axis[k].beg[POS_W-1], walk.axis[k].beg}, walk.axis[k]))
                begin_out = 1'b1;
        end
        fin_now = first ? begin_out : finished_reg;

        // innermost axis steps; an axis that leaves its range reloads and carries
        carry = 1'b1;
        for (int k = NUM_AXES - 1; k >= 0; k--)
        begin
            n = $signed({pos_start[k][POS_W-1], pos_start[k]})
                + $signed({{2{walk.axis[k].step[STEP_W-1]}}, walk.axis[k].step});
            pos_adv[k] = pos_start[k];
            if (carry)
            begin
                if (inside_walk(n, walk.axis[k]))
                begin
                    pos_adv[k] = n[POS_W-1:0];
                    carry      = 1'b0;
                end
                else
                    pos_adv[k] = walk.axis[k].beg;
            end
        end
    end

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
            ctrl.pos[k] = pos_start[k];
        if (walk.zero_stride)
            ctrl.fault = FAULT_ZERO_STRIDE;
        else if (fin_now)
            ctrl.fault = FAULT_DONE;
        else
            ctrl.fault = FAULT_OK;
        ctrl.last = !walk.zero_stride && !fin_now && carry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < NUM_AXES; k++)
                pos_reg[k] <= '0;
            finished_reg <= 1'b1;
        end
        else if (push && !walk.zero_stride)
        begin
            for (int k = 0; k < NUM_AXES; k++)
                pos_reg[k] <= fin_now ? pos_start[k] : pos_adv[k];
            finished_reg <= fin_now ? 1'b1 : carry;
        end
    end

    a_last_ends_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (push && ctrl.last) |=> finished_reg)
        else $error("walk still open after last beat");

    a_last_is_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (push && ctrl.last) |-> (ctrl.fault == FAULT_OK))
        else $error("last beat carries a fault");

    a_no_push_settling: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !cfg_busy)
        else $error("beat taken while configuration settles");

endmodule

### sv/sssag_queue.sv
// ============================================================================
// sssag_queue
// Short register queue between the walk front end and the address back end.
// ============================================================================
module sssag_queue #(
    parameter int DATA_BITS = 64
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  wr_en,
    input  sssag_pkg::q_ctrl_t    wr_ctrl,
    input  logic [DATA_BITS-1:0]  wr_data,
    output logic                  wr_ready,
    input  logic                  rd_en,
    output logic                  rd_valid,
    output sssag_pkg::q_ctrl_t    rd_ctrl,
    output logic [DATA_BITS-1:0]  rd_data
);
    import sssag_pkg::*;

    localparam int PTR_W = $clog2(QUEUE_DEPTH);
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    q_ctrl_t              slot_ctrl_reg [QUEUE_DEPTH];
    logic [DATA_BITS-1:0] slot_data_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0]     wr_ptr_reg;
    logic [PTR_W-1:0]     rd_ptr_reg;
    logic [CNT_W-1:0]     count_reg;

    assign wr_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_ctrl  = slot_ctrl_reg[rd_ptr_reg];
    assign rd_data  = slot_data_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            slot_ctrl_reg[wr_ptr_reg] <= wr_ctrl;
            slot_data_reg[wr_ptr_reg] <= wr_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (wr_en)
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            if (rd_en)
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            if (wr_en && !rd_en)
                count_reg <= count_reg + 1'b1;
            else if (rd_en && !wr_en)
                count_reg <= count_reg - 1'b1;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        rd_en |-> (count_reg != '0))
        else $error("queue read while empty");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        wr_en |-> (count_reg != CNT_W'(QUEUE_DEPTH)))
        else $error("queue written while full");

endmodule

### sv/sssag_back.sv
// ============================================================================
// sssag_back
// Address pipeline: scales axis positions, sums them, range-checks the
// result and drives the output register.
// ============================================================================
module sssag_back #(
    parameter int ADDR_BITS = 32,
    parameter int DATA_BITS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  sssag_pkg::cfg_scale_t                  scale,
    input  logic                                   head_valid,
    input  sssag_pkg::q_ctrl_t                     head_ctrl,
    input  logic [DATA_BITS-1:0]                   head_data,
    output logic                                   pop,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] write_address, [95:32] write_value
    output logic [sssag_pkg::OUT_ADDR_W+sssag_pkg::OUT_VALUE_W-1:0] m_tdata,
    output logic                                   m_tlast,
    // [1:0] fault
    output logic [1:0]                             m_tuser
);
    import sssag_pkg::*;

    localparam logic [63:0] ADDR_LIMIT = (64'd1 << ADDR_BITS) - 64'd1;

    logic                 s1_valid_reg;
    logic [E1_W+15:0]     s1_m0_reg;
    logic [E2_W+15:0]     s1_m1_reg;
    logic [SIZE_W+15:0]   s1_m2_reg;
    logic [15:0]          s1_m3_reg;
    logic                 s1_neg_reg;
    fault_t               s1_fault_reg;
    logic                 s1_last_reg;
    logic [DATA_BITS-1:0] s1_data_reg;

    logic                 s2_valid_reg;
    logic [63:0]          s2_sum_reg;
    logic                 s2_neg_reg;
    fault_t               s2_fault_reg;
    logic                 s2_last_reg;
    logic [DATA_BITS-1:0] s2_data_reg;

    logic                  out_valid_reg;
    logic [OUT_ADDR_W-1:0] out_addr_reg;
    fault_t                out_fault_reg;
    logic                  out_last_reg;
    logic [DATA_BITS-1:0]  out_data_reg;

    logic   adv_out;
    logic   adv_s2;
    logic   adv_s1;
    logic   range_bad;
    fault_t fault_res;

    assign adv_out = !out_valid_reg || m_tready;
    assign adv_s2  = !s2_valid_reg || adv_out;
    assign adv_s1  = !s1_valid_reg || adv_s2;
    assign pop     = head_valid && adv_s1;

    assign range_bad = s2_neg_reg || (s2_sum_reg >= 64'(scale.total))
                       || (s2_sum_reg > ADDR_LIMIT);

    always_comb
    begin
        if (s2_fault_reg != FAULT_OK)
            fault_res = s2_fault_reg;
        else if (range_bad)
            fault_res = FAULT_RANGE;
        else
            fault_res = FAULT_OK;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv_s1)
                s1_valid_reg <= head_valid;
            if (adv_s2)
                s2_valid_reg <= s1_valid_reg;
            if (adv_out)
                out_valid_reg <= s2_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_s1)
        begin
            s1_m0_reg    <= head_ctrl.pos[0][15:0] * scale.e1;
            s1_m1_reg    <= head_ctrl.pos[1][15:0] * scale.e2;
            s1_m2_reg    <= head_ctrl.pos[2][15:0] * scale.e3;
            s1_m3_reg    <= head_ctrl.pos[3][15:0];
            s1_neg_reg   <= head_ctrl.pos[0][POS_W-1] | head_ctrl.pos[1][POS_W-1]
                            | head_ctrl.pos[2][POS_W-1] | head_ctrl.pos[3][POS_W-1];
            s1_fault_reg <= head_ctrl.fault;
            s1_last_reg  <= head_ctrl.last;
            s1_data_reg  <= head_data;
        end
        if (adv_s2)
        begin
            s2_sum_reg   <= 64'(s1_m0_reg) + 64'(s1_m1_reg) + 64'(s1_m2_reg)
                            + 64'(s1_m3_reg);
            s2_neg_reg   <= s1_neg_reg;
            s2_fault_reg <= s1_fault_reg;
            s2_last_reg  <= s1_last_reg;
            s2_data_reg  <= s1_data_reg;
        end
        if (adv_out)
        begin
            // drop the address on any fault
            out_addr_reg  <= (fault_res == FAULT_OK) ? s2_sum_reg[OUT_ADDR_W-1:0] : '0;
            out_fault_reg <= fault_res;
            out_last_reg  <= s2_last_reg;
            out_data_reg  <= s2_data_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {OUT_VALUE_W'(out_data_reg), out_addr_reg};
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_fault_reg;

    a_fault_kept: assert property (@(posedge clk) disable iff (!rst_n)
        (adv_out && s2_valid_reg && s2_fault_reg != FAULT_OK)
        |=> (out_fault_reg == $past(s2_fault_reg)))
        else $error("front-end fault lost in address pipeline");

endmodule

### sv/strided_slice_scatter_addr_gen.sv
// ============================================================================
// strided_slice_scatter_addr_gen
// Four-axis strided or sized slice scatter: one destination write per beat.
// ============================================================================
// Input stream s_*: one gradient element per beat, tuser set on the first
// element restarts the walk at the normalised begin of every axis.
// Output stream m_*: destination element address and the value, tlast on the
// final element of the slice, tuser carries the fault code (address zero on
// any fault).
// Throughput is one beat per cycle while the queue has room and the
// configuration has settled, set by the odometer update in the front end;
// accepted beats pass the queue and the multiply, sum and range-check stages.
// A four-entry queue sits between front and back, so s_tready stays high
// while m_tready is low until the queue and pipeline have filled.
// Configuration is written through cfg_we/cfg_addr/cfg_wdata; the user must
// do so only while idle (the block does not enforce it); after each write and
// after reset, s_tready drops while the axis bounds and inner size products settle.
// Reset (rst_n low) clears the queue and pipeline, zeroes the positions and
// marks the walk finished until a first element arrives.
// ============================================================================
module strided_slice_scatter_addr_gen #(
    parameter int AXES      = 4,
    parameter int ADDR_BITS = 32,
    parameter int DATA_BITS = 64
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   s_tvalid,
    output logic                                   s_tready,
    // [63:0] element_value
    input  logic [sssag_pkg::IN_VALUE_W-1:0]       s_tdata,
    // [0] first
    input  logic                                   s_tuser,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    // [31:0] write_address, [95:32] write_value
    output logic [sssag_pkg::OUT_ADDR_W+sssag_pkg::OUT_VALUE_W-1:0] m_tdata,
    output logic                                   m_tlast,
    // [1:0] fault
    output logic [1:0]                             m_tuser,
    input  logic                                   cfg_we,
    input  logic [sssag_pkg::CFG_ADDR_W-1:0]       cfg_addr,
    input  logic [sssag_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
    import sssag_pkg::*;

    cfg_walk_t            walk;
    cfg_scale_t           scale;
    logic                 cfg_busy;
    logic                 push;
    q_ctrl_t              push_ctrl;
    logic                 queue_ready;
    logic                 pop;
    logic                 head_valid;
    q_ctrl_t              head_ctrl;
    logic [DATA_BITS-1:0] head_data;

    sssag_cfg #(
        .AXES (AXES)
    ) u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .walk      (walk),
        .scale     (scale),
        .busy      (cfg_busy)
    );

    sssag_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .first       (s_tuser),
        .queue_ready (queue_ready),
        .cfg_busy    (cfg_busy),
        .walk        (walk),
        .push        (push),
        .ctrl        (push_ctrl)
    );

    sssag_queue #(
        .DATA_BITS (DATA_BITS)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (push),
        .wr_ctrl  (push_ctrl),
        .wr_data  (s_tdata[DATA_BITS-1:0]),
        .wr_ready (queue_ready),
        .rd_en    (pop),
        .rd_valid (head_valid),
        .rd_ctrl  (head_ctrl),
        .rd_data  (head_data)
    );

    sssag_back #(
        .ADDR_BITS (ADDR_BITS),
        .DATA_BITS (DATA_BITS)
    ) u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .scale      (scale),
        .head_valid (head_valid),
        .head_ctrl  (head_ctrl),
        .head_data  (head_data),
        .pop        (pop),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

### sim/tb_top.sv
`timescale 1ns / 1ps
// ============================================================================
// tb_top
// Stream-level check of the strided slice scatter address generator. Elements
// go in through a randomly idling driver and writes come back through a
// randomly stalling monitor. Every write is compared with an in-bench model of
// the axis normalisation and odometer walk. A short directed part runs first,
// then randomised register setups, each followed by whole, truncated and
// overrunning walks.
// ============================================================================
module tb_top;
    import sssag_pkg::*;

    localparam int ITEMS       = 1100;
    localparam int TAIL_CYCLES = 8;
    localparam int CYCLE_LIMIT = 300000;

    localparam logic [CFG_ADDR_W-1:0] AXIS_REG [4] = '{REG_AXIS0, REG_AXIS1, REG_AXIS2, REG_AXIS3};

    typedef struct {
        int size;
        int lo;
        int hi;
        int step;
    } span_t;

    typedef struct packed {
        logic [63:0] value;
        logic        first;
    } element_t;

    typedef struct packed {
        logic [31:0] addr;
        logic [63:0] value;
        logic        last;
        fault_t      fault;
    } scatter_t;

    logic         clk       = 1'b0;
    logic         rst_n     = 1'b0;
    logic         s_tvalid  = 1'b0;
    logic         s_tready;
    logic [63:0]  s_tdata   = '0;
    logic         s_tuser   = 1'b0;
    logic         m_tvalid;
    logic         m_tready  = 1'b0;
    logic [95:0]  m_tdata;
    logic         m_tlast;
    logic [1:0]   m_tuser;
    logic         cfg_we    = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;

    // model state: register copies, axis positions and walk status
    logic [63:0]  axis_reg [4] = '{default: AXIS_SETUP_RESET};
    logic         strided_mode = 1'b0;
    int           axis_pos [4] = '{default: 0};
    bit           walk_done    = 1'b1;

    element_t     pending_elements [$];
    scatter_t     expected_writes [$];
    element_t     next_element;
    scatter_t     want;
    bit           steady = 1'b0;
    int           errors = 0;
    int           item_count = 0;
    int           walks_closed = 0;
    int           faults_seen [4] = '{default: 0};
    int unsigned  cycle_count = 0;

    strided_slice_scatter_addr_gen DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .m_tuser   (m_tuser),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] axis_word(input int size, input int beg,
                                              input int lim, input int step);
        logic [15:0] f0, f1, f2, f3;
        f0 = size[15:0];
        f1 = beg[15:0];
        f2 = lim[15:0];
        f3 = step[15:0];
        return {f3, f2, f1, f0};
    endfunction

    function automatic span_t bound_axis(input logic [63:0] r, input logic strided);
        span_t a;
        int b;
        int e;
        a.size = $signed(r[15:0]);
        b      = $signed(r[31:16]);
        e      = $signed(r[47:32]);
        a.step = $signed(r[63:48]);
        if (a.size < 0)
            a.size = 0;
        if (strided)
        begin
            // an end of zero with a negative begin means the whole axis
            if (e == 0 && b < 0)
                e += a.size;
            if (e < 0)
            begin
                e += a.size;
                if (e < 0)
                    e = 0;
            end
            if (e > a.size)
                e = a.size;
        end
        if (b < 0)
        begin
            b += a.size;
            if (b < 0)
                b = 0;
        end
        if (b > a.size)
            b = a.size;
        if (!strided)
        begin
            if (e < 0)
            begin
                e += a.size;
                if (e < 0)
                    e = 0;
            end
            a.step = 1;
            e = b + e;
        end
        a.lo = b;
        a.hi = e;
        return a;
    endfunction

    function automatic bit in_walk(input int p, input span_t a);
        return (a.step > 0) ? (p < a.hi) : (p > a.hi);
    endfunction

    function automatic int wrap17(input int v);
        logic signed [16:0] t;
        t = v[16:0];
        return t;
    endfunction

    // one element in, one destination write out; advances the odometer on an open walk with nonzero strides
    function automatic scatter_t scatter_element(input logic [63:0] value, input logic first);
        span_t ax [4];
        bit zero_step;
        bit neg;
        bit carry;
        longint unsigned addr;
        longint unsigned elems;
        longint unsigned p64;
        int n;
        scatter_t r;
        r.addr  = '0;
        r.value = value;
        r.last  = 1'b0;
        r.fault = FAULT_OK;
        zero_step = 1'b0;
        for (int k = 0; k < 4; k++)
        begin
            ax[k] = bound_axis(axis_reg[k], strided_mode);
            if (ax[k].step == 0)
                zero_step = 1'b1;
        end
        if (zero_step)
        begin
            r.fault = FAULT_ZERO_STRIDE;
            return r;
        end
        if (first)
        begin
            walk_done = 1'b0;
            for (int k = 0; k < 4; k++)
            begin
                axis_pos[k] = ax[k].lo;
                if (!in_walk(ax[k].lo, ax[k]))
                    walk_done = 1'b1;
            end
        end
        if (walk_done)
        begin
            r.fault = FAULT_DONE;
            return r;
        end
        addr  = 0;
        elems = 1;
        neg   = 1'b0;
        for (int k = 3; k >= 0; k--)
        begin
            if (axis_pos[k] < 0)
                neg = 1'b1;
            else
            begin
                p64 = axis_pos[k];
                addr += p64 * elems;
            end
            p64 = ax[k].size;
            elems *= p64;
        end
        if (neg || addr >= elems || addr > 64'hFFFF_FFFF)
            r.fault = FAULT_RANGE;
        carry = 1'b1;
        for (int k = 3; k >= 0 && carry; k--)
        begin
            n = axis_pos[k] + ax[k].step;
            if (in_walk(n, ax[k]))
            begin
                axis_pos[k] = wrap17(n);
                carry = 1'b0;
            end
            else
                axis_pos[k] = wrap17(ax[k].lo);
        end
        if (carry)
        begin
            walk_done = 1'b1;
            r.last = 1'b1;
        end
        if (r.fault == FAULT_OK)
            r.addr = addr[31:0];
        return r;
    endfunction

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [63:0] val);
        @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= idx;
        cfg_wdata <= val;
        if (idx == REG_MODE)
            strided_mode = val[0];
        else
            axis_reg[idx[1:0]] = val;
    endtask

    task automatic end_writes();
        @(posedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    task automatic put_element(input logic [63:0] value, input logic first);
        pending_elements.insert(pending_elements.size(), '{value: value, first: first});
        item_count++;
    endtask

    // hold until every element is out and every write is back
    task automatic drain();
        do
            @(negedge clk);
        while (pending_elements.size() != 0 || s_tvalid || expected_writes.size() != 0);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
            s_tdata  <= '0;
            s_tuser  <= 1'b0;
        end
        else
        begin
            if (s_tvalid && s_tready)
                expected_writes.insert(expected_writes.size(),
                                       scatter_element(s_tdata, s_tuser));
            if (!s_tvalid || s_tready)
            begin
                if (pending_elements.size() != 0 && (steady || $urandom_range(0, 99) >= 35))
                begin
                    next_element = pending_elements.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= next_element.value;
                    s_tuser  <= next_element.first;
                end
                else
                    s_tvalid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
        begin
            if (m_tvalid && m_tready)
            begin
                if (expected_writes.size() == 0)
                begin
                    $error("write beat with nothing expected: address %h fault %0d",
                           m_tdata[31:0], m_tuser);
                    errors++;
                end
                else
                begin
                    want = expected_writes.pop_front();
                    if (m_tdata[31:0] !== want.addr)
                    begin
                        $error("write_address: expected %h, got %h", want.addr, m_tdata[31:0]);
                        errors++;
                    end
                    if (m_tdata[95:32] !== want.value)
                    begin
                        $error("write_value: expected %h, got %h", want.value, m_tdata[95:32]);
                        errors++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last: expected %0d, got %0d", want.last, m_tlast);
                        errors++;
                    end
                    if (m_tuser !== want.fault)
                    begin
                        $error("fault: expected %0d, got %0d", want.fault, m_tuser);
                        errors++;
                    end
                    faults_seen[want.fault]++;
                    if (want.last)
                        walks_closed++;
                end
            end
            m_tready <= steady || ($urandom_range(0, 99) >= 35);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("status: fail");
            $finish;
        end
    end

    initial
    begin
        span_t a;
        longint span;
        int len;
        int n_walks;
        int phase;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset setup leaves the walk finished, with or without a restart
        put_element(64'd0, 1'b0);
        put_element('1, 1'b1);
        drain();

        // sized slice: wrapped begin, carry across two axes, overrun past the end
        write_reg(REG_MODE, 64'd0);
        write_reg(AXIS_REG[0], axis_word(1, 0, 1, 0));
        write_reg(AXIS_REG[1], axis_word(2, -1, 1, 0));
        write_reg(AXIS_REG[2], axis_word(2, 0, 2, 0));
        write_reg(AXIS_REG[3], axis_word(3, 1, 3, 0));
        end_writes();
        put_element(64'hAAAA_AAAA_AAAA_AAAA, 1'b1);
        repeat (6) put_element({$urandom, $urandom}, 1'b0);
        drain();

        // strided: zero end with negative begin, negative stride, restart after the final element
        write_reg(REG_MODE, 64'd1);
        write_reg(AXIS_REG[1], axis_word(1, 0, 1, 1));
        write_reg(AXIS_REG[0], axis_word(1, 0, 1, 1));
        write_reg(AXIS_REG[2], axis_word(3, -2, 0, 1));
        write_reg(AXIS_REG[3], axis_word(4, 3, -5, -2));
        end_writes();
        put_element(64'h5555_5555_5555_5555, 1'b1);
        repeat (3) put_element({$urandom, $urandom}, 1'b0);
        put_element({$urandom, $urandom}, 1'b1);
        drain();

        // zero stride blocks everything, a restart included
        write_reg(AXIS_REG[1], axis_word(1, 0, 1, 0));
        end_writes();
        put_element({$urandom, $urandom}, 1'b1);
        put_element({$urandom, $urandom}, 1'b0);
        drain();

        // begin already past the end: empty walk
        write_reg(AXIS_REG[1], axis_word(5, 3, 2, 1));
        end_writes();
        put_element({$urandom, $urandom}, 1'b1);
        put_element({$urandom, $urandom}, 1'b0);
        drain();

        // largest sizes and positions: the address no longer fits 32 bits
        write_reg(REG_MODE, 64'd0);
        for (int k = 0; k < 4; k++)
            write_reg(AXIS_REG[k], axis_word(32767, 32766, 32767, -32768));
        end_writes();
        put_element('1, 1'b1);
        put_element(64'd0, 1'b0);
        put_element({$urandom, $urandom}, 1'b0);
        drain();

        phase = 0;
        while (item_count < ITEMS)
        begin
            phase++;
            steady = (phase >= 10 && phase < 30);
            for (int k = 0; k < 4; k++)
                if (phase == 1 || $urandom_range(0, 99) < 60)
                begin
                    if ($urandom_range(0, 99) < 7)
                        write_reg(AXIS_REG[k], {$urandom, $urandom});
                    else
                        write_reg(AXIS_REG[k], axis_word(
                            ($urandom_range(0, 99) < 8) ? -int'($urandom_range(1, 3))
                                                        : int'($urandom_range(0, 5)),
                            int'($urandom_range(0, 14)) - 7,
                            int'($urandom_range(0, 14)) - 7,
                            ($urandom_range(0, 99) < 6) ? 0
                                : int'($urandom_range(1, 3))
                                  * (($urandom_range(0, 1) == 1) ? 1 : -1)));
                end
            if (phase == 1 || $urandom_range(0, 99) < 50)
                write_reg(REG_MODE, ($urandom_range(0, 1) == 1) ? 64'd1 : 64'd0);
            end_writes();

            // elements in one full walk under the new setup, capped
            span = 1;
            for (int k = 0; k < 4; k++)
            begin
                a = bound_axis(axis_reg[k], strided_mode);
                if (a.step == 0 || !in_walk(a.lo, a))
                    span = 0;
                else if (a.step > 0)
                    span *= (a.hi - a.lo + a.step - 1) / a.step;
                else
                    span *= (a.lo - a.hi - a.step - 1) / (-a.step);
                if (span > 1000)
                    span = 1000;
            end

            n_walks = $urandom_range(1, 3);
            for (int w = 0; w < n_walks; w++)
            begin
                if (span == 0)
                    repeat ($urandom_range(1, 3))
                        put_element({$urandom, $urandom}, $urandom_range(0, 1) == 1);
                else
                begin
                    len = (span > 48) ? $urandom_range(1, 48) : int'(span);
                    if ($urandom_range(0, 99) < 20)
                        len = $urandom_range(1, len);
                    // now and then carry on from the old positions under the new setup
                    put_element({$urandom, $urandom}, !(w == 0 && $urandom_range(0, 99) < 10));
                    repeat (len - 1)
                        put_element({$urandom, $urandom}, $urandom_range(0, 99) < 3);
                    if ($urandom_range(0, 99) < 20)
                        repeat ($urandom_range(1, 2))
                            put_element({$urandom, $urandom}, 1'b0);
                end
            end
            drain();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("%0d elements over %0d register setups, %0d walks run to their final element",
                 item_count, phase + 6, walks_closed);
        $display("writes by fault: ok %0d, finished %0d, zero stride %0d, out of range %0d",
                 faults_seen[FAULT_OK], faults_seen[FAULT_DONE],
                 faults_seen[FAULT_ZERO_STRIDE], faults_seen[FAULT_RANGE]);
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
